// ===== hw/rtl/bnpr_pkg.sv =====
`default_nettype none

package bnpr_pkg;

  // Major opcodes of the branch and jump instructions.
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_COP1    = 6'd17;
  localparam logic [5:0] OP_BEQL    = 6'd20;
  localparam logic [5:0] OP_BNEL    = 6'd21;
  localparam logic [5:0] OP_BLEZL   = 6'd22;
  localparam logic [5:0] OP_BGTZL   = 6'd23;

  // Function codes of the register jumps.
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_JALR = 6'd9;

  // The rs field that selects the coprocessor 1 branch group.
  localparam logic [4:0] COP1_BC = 5'd8;

  // Register that receives the return address of the fixed linking forms.
  localparam logic [4:0] LINK_REG = 5'd31;

  localparam logic [31:0] INSN_BYTES = 32'd4;
  localparam logic [31:0] SLOT_BYTES = 32'd8;

  // How the continuation address is formed.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_REG,
    KIND_JUMP,
    KIND_COND
  } kind_t;

  // Which test decides a conditional branch.
  typedef enum logic [2:0] {
    COND_EQ,
    COND_NE,
    COND_LEZ,
    COND_GTZ,
    COND_LTZ,
    COND_GEZ,
    COND_FT,
    COND_FF
  } cond_t;

  typedef struct packed {
    logic [31:0] pc_addr;
    logic [31:0] instr_word;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic        fp_cond;
  } request_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        link_enable;
    logic [4:0]  link_index;
    logic [31:0] link_value;
    logic        error_status;
  } result_t;

  // Link request, carried unchanged down the pipeline.
  typedef struct packed {
    logic        enable;
    logic [4:0]  index;
    logic [31:0] value;
  } link_t;

  // Contents of the decode stage register.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    cond_t       cond;
    logic [31:0] pc;
    logic [31:0] pc4;
    logic [31:0] pc8;
    logic [31:0] rs_val;
    logic [31:0] rt_val;
    logic        fcc;
    logic [25:0] imm;
    link_t       link;
    logic        err;
  } dec_t;

  // Contents of the evaluate stage register.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        take;
    logic [31:0] pc;
    logic [31:0] pc8;
    logic [31:0] branch_target;
    logic [31:0] jump_target;
    logic [31:0] reg_target;
    link_t       link;
    logic        err;
  } eval_t;

endpackage

`default_nettype wire

// ===== hw/rtl/branch_next_pc_resolver.sv =====
`default_nettype none

// Branch and jump next-address resolver. Each item carries a branch or jump
// instruction, its address, its two source register values and the FPU
// condition bit; the block returns the address that follows the delay slot,
// an optional link write of address+8, and an unaligned-address flag. An item
// is taken on any cycle that start is high (busy stays low, since the
// receiver cannot stall), and its result appears on result with done high
// after the pipeline registers of decode, condition and target adds, and the
// final select, one register each. One item per clock sustained.
module branch_next_pc_resolver (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire bnpr_pkg::request_t request,
  output logic                    done,
  output bnpr_pkg::result_t       result
);

  bnpr_pkg::dec_t  dec;
  bnpr_pkg::eval_t ev;
  logic [31:0]     next_pc;

  assign busy = 1'b0;

  bnpr_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (start),
    .request (request),
    .dec     (dec)
  );

  bnpr_eval u_eval (
    .clk (clk),
    .rst (rst),
    .dec (dec),
    .ev  (ev)
  );

  // Pick the continuation address.
  always_comb begin
    case (ev.kind)
      bnpr_pkg::KIND_REG:  next_pc = ev.reg_target;
      bnpr_pkg::KIND_JUMP: next_pc = ev.jump_target;
      bnpr_pkg::KIND_COND: next_pc = ev.take ? ev.branch_target : ev.pc8;
      default:             next_pc = ev.pc;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ev.valid;
    end
  end

  always_ff @(posedge clk) begin
    result.next_pc      <= next_pc;
    result.link_enable  <= ev.link.enable;
    result.link_index   <= ev.link.index;
    result.link_value   <= ev.link.value;
    result.error_status <= ev.err;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bnpr_decode.sv =====
`default_nettype none

module bnpr_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire bnpr_pkg::request_t request,
  output bnpr_pkg::dec_t         dec
);

  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [5:0]  fn;
  logic [31:0] pc8;
  logic [31:0] pc4;
  logic [31:0] rs_val;
  logic [31:0] rt_val;
  bnpr_pkg::kind_t kind;
  bnpr_pkg::cond_t cond;
  bnpr_pkg::link_t link;
  logic        err;

  assign op  = request.instr_word[31:26];
  assign rs  = request.instr_word[25:21];
  assign rt  = request.instr_word[20:16];
  assign rd  = request.instr_word[15:11];
  assign fn  = request.instr_word[5:0];
  assign pc8 = request.pc_addr + bnpr_pkg::SLOT_BYTES;
  assign pc4 = request.pc_addr + bnpr_pkg::INSN_BYTES;

  // Classify the instruction, apply register zero and the link-before-read rule.
  always_comb begin
    rs_val      = (rs == 5'd0) ? 32'd0 : request.rs_value;
    rt_val      = (rt == 5'd0) ? 32'd0 : request.rt_value;
    kind        = bnpr_pkg::KIND_NONE;
    cond        = bnpr_pkg::COND_EQ;
    link.enable = 1'b0;
    link.index  = 5'd0;
    link.value  = 32'd0;
    err         = 1'b0;
    if (request.pc_addr[1:0] != 2'b00) begin
      err = 1'b1;
    end else begin
      case (op)
        bnpr_pkg::OP_SPECIAL: begin
          if (fn == bnpr_pkg::FN_JALR) begin
            kind        = bnpr_pkg::KIND_REG;
            link.enable = 1'b1;
            link.index  = rd;
            link.value  = pc8;
            if (rs == rd) begin
              rs_val = pc8;
            end
          end else if (fn == bnpr_pkg::FN_JR) begin
            kind = bnpr_pkg::KIND_REG;
          end
        end
        bnpr_pkg::OP_REGIMM: begin
          // Only rt codes 0 to 3 and 16 to 19 are branches.
          if (rt[3:2] == 2'b00) begin
            kind = bnpr_pkg::KIND_COND;
            cond = rt[0] ? bnpr_pkg::COND_GEZ : bnpr_pkg::COND_LTZ;
            if (rt[4]) begin
              link.enable = 1'b1;
              link.index  = bnpr_pkg::LINK_REG;
              link.value  = pc8;
              if (rs == bnpr_pkg::LINK_REG) begin
                rs_val = pc8;
              end
            end
          end
        end
        bnpr_pkg::OP_J: begin
          kind = bnpr_pkg::KIND_JUMP;
        end
        bnpr_pkg::OP_JAL: begin
          kind        = bnpr_pkg::KIND_JUMP;
          link.enable = 1'b1;
          link.index  = bnpr_pkg::LINK_REG;
          link.value  = pc8;
        end
        bnpr_pkg::OP_BEQ, bnpr_pkg::OP_BEQL: begin
          kind = bnpr_pkg::KIND_COND;
          cond = bnpr_pkg::COND_EQ;
        end
        bnpr_pkg::OP_BNE, bnpr_pkg::OP_BNEL: begin
          kind = bnpr_pkg::KIND_COND;
          cond = bnpr_pkg::COND_NE;
        end
        bnpr_pkg::OP_BLEZ, bnpr_pkg::OP_BLEZL: begin
          kind = bnpr_pkg::KIND_COND;
          cond = bnpr_pkg::COND_LEZ;
        end
        bnpr_pkg::OP_BGTZ, bnpr_pkg::OP_BGTZL: begin
          kind = bnpr_pkg::KIND_COND;
          cond = bnpr_pkg::COND_GTZ;
        end
        bnpr_pkg::OP_COP1: begin
          // Branch on condition code 0 only.
          if (rs == bnpr_pkg::COP1_BC && rt[4:2] == 3'b000) begin
            kind = bnpr_pkg::KIND_COND;
            cond = rt[0] ? bnpr_pkg::COND_FT : bnpr_pkg::COND_FF;
          end
        end
        default: begin
          kind = bnpr_pkg::KIND_NONE;
        end
      endcase
    end
  end

  // Stage register: valid is control and is reset, the rest is payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid <= 1'b0;
    end else begin
      dec.valid <= accept;
    end
    dec.kind   <= kind;
    dec.cond   <= cond;
    dec.pc     <= request.pc_addr;
    dec.pc4    <= pc4;
    dec.pc8    <= pc8;
    dec.rs_val <= rs_val;
    dec.rt_val <= rt_val;
    dec.fcc    <= request.fp_cond;
    dec.imm    <= request.instr_word[25:0];
    dec.link   <= link;
    dec.err    <= err;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bnpr_eval.sv =====
`default_nettype none

module bnpr_eval (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bnpr_pkg::dec_t dec,
  output bnpr_pkg::eval_t     ev
);

  logic        rs_neg;
  logic        rs_zero;
  logic        take;
  logic [31:0] offset;

  assign rs_neg  = dec.rs_val[31];
  assign rs_zero = (dec.rs_val == 32'd0);
  assign offset  = {{14{dec.imm[15]}}, dec.imm[15:0], 2'b00};

  // Evaluate the branch condition.
  always_comb begin
    case (dec.cond)
      bnpr_pkg::COND_EQ:  take = (dec.rs_val == dec.rt_val);
      bnpr_pkg::COND_NE:  take = (dec.rs_val != dec.rt_val);
      bnpr_pkg::COND_LEZ: take = rs_neg || rs_zero;
      bnpr_pkg::COND_GTZ: take = !rs_neg && !rs_zero;
      bnpr_pkg::COND_LTZ: take = rs_neg;
      bnpr_pkg::COND_GEZ: take = !rs_neg;
      bnpr_pkg::COND_FT:  take = dec.fcc;
      bnpr_pkg::COND_FF:  take = !dec.fcc;
      default:            take = 1'b0;
    endcase
  end

  // Candidate targets; the jump keeps the top four bits of the delay slot address.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev.valid <= 1'b0;
    end else begin
      ev.valid <= dec.valid;
    end
    ev.kind          <= dec.kind;
    ev.take          <= take;
    ev.pc            <= dec.pc;
    ev.pc8           <= dec.pc8;
    ev.branch_target <= dec.pc4 + offset;
    ev.jump_target   <= {dec.pc4[31:28], dec.imm, 2'b00};
    ev.reg_target    <= dec.rs_val;
    ev.link          <= dec.link;
    ev.err           <= dec.err;
  end

endmodule

`default_nettype wire
